// ----- design/dvpc_pkg.sv -----
// Shared types and constants for the DVP camera pixel capture block.
`default_nettype none
package dvpc_pkg;

  // Widths of the configuration registers and payload fields.
  localparam int unsigned LinePixW  = 10;
  localparam int unsigned FrameLinW = 9;
  localparam int unsigned IndexW    = 19;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned CfgIndexW = 2;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgLinePixels = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgFrameLines = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgGrayMode   = 2'd2;

  // Register reset values.
  localparam logic [LinePixW-1:0]  LinePixelsReset = 10'd160;
  localparam logic [FrameLinW-1:0] FrameLinesReset = 9'd120;

  // One sample of the camera pins plus the start request.
  typedef struct packed {
    logic       start_req;
    logic       vsync;
    logic       href;
    logic       pclk;
    logic [7:0] pin_byte;
  } in_item_t;

  // One captured pixel.
  typedef struct packed {
    logic [15:0]       pixel_value;
    logic [IndexW-1:0] pixel_index;
    logic              frame_last;
  } out_item_t;

  // Configuration write bundle.
  typedef struct packed {
    logic                 write;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
  } cfg_write_t;

endpackage
`default_nettype wire

// ----- design/dvp_camera_pixel_capture.sv -----
// Top level of the DVP camera pixel capture block.
`default_nettype none
// Captures one frame from a parallel camera port, one pin sample per transfer on the
// input channel. A start request while idle arms the block; it then waits for VSYNC
// high and low, and for each line waits for HREF high and takes line_pixels pixels,
// each made of two PCLK low phases. Pixels come out as RGB565 words, or gray bytes,
// with their row-major index, and the final pixel is marked frame_last. The block
// takes one sample every cycle while its output queue has room. Pixels pass through
// a two-entry queue ahead of the output channel, and in_ready drops only while that
// queue holds two untaken pixels; each pixel is registered there before it is output.
module dvp_camera_pixel_capture #(
  parameter int unsigned MAX_PIXELS_PER_LINE = 640,
  parameter int unsigned MAX_LINES           = 480
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [dvpc_pkg::CfgIndexW-1:0]      cfg_index,
  input  wire logic [dvpc_pkg::CfgDataW-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire dvpc_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output dvpc_pkg::out_item_t                      out_data
);
  import dvpc_pkg::*;

  cfg_write_t cfg;
  logic       res_valid;
  out_item_t  res_item;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Sample sequencer.
  dvpc_front #(
    .MAX_PIXELS_PER_LINE(MAX_PIXELS_PER_LINE),
    .MAX_LINES          (MAX_LINES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_item  (in_data),
    .in_ready (in_ready),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  // Output queue.
  dvpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_item(res_item),
    .has_room (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // A pixel is only built while the queue has room for it.
  assert property (@(posedge clk) disable iff (rst) res_valid |-> in_ready)
    else $error("pixel built while the queue is full");

  // Two pixels are always separated by a PCLK high sample.
  assert property (@(posedge clk) disable iff (rst) res_valid |=> !res_valid)
    else $error("pixels built on consecutive cycles");

  // Reset empties the queue.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// ----- design/dvpc_front.sv -----
// Front end: accepts pin samples, tracks frame, line and pixel timing, builds pixels.
`default_nettype none
module dvpc_front #(
  parameter int unsigned MAX_PIXELS_PER_LINE = 640,
  parameter int unsigned MAX_LINES           = 480
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dvpc_pkg::cfg_write_t cfg,
  input  wire logic                in_valid,
  input  wire dvpc_pkg::in_item_t  in_item,
  input  wire logic                in_ready,
  output logic                     res_valid,
  output dvpc_pkg::out_item_t      res_item
);
  import dvpc_pkg::*;

  typedef enum logic [2:0] {
    IDLE, VS_HIGH, VS_LOW, HREF_WAIT, LOW1, HIGH1, LOW2, HIGH2
  } phase_t;

  phase_t               phase;
  logic [LinePixW-1:0]  line_pixels;
  logic [FrameLinW-1:0] frame_lines;
  logic                 gray_mode;
  logic [LinePixW-1:0]  pixels_left;
  logic [FrameLinW-1:0] lines_left;
  logic [IndexW-1:0]    write_index;
  logic [7:0]           upper_byte;

  logic                 accept;
  logic [LinePixW-1:0]  line_count;
  logic [FrameLinW-1:0] frame_count;
  logic                 line_end;

  assign accept = in_valid && in_ready;

  // Register values limited to the configured maximum sizes.
  always_comb begin
    if (32'(line_pixels) > MAX_PIXELS_PER_LINE) begin
      line_count = LinePixW'(MAX_PIXELS_PER_LINE);
    end else begin
      line_count = line_pixels;
    end
    if (32'(frame_lines) > MAX_LINES) begin
      frame_count = FrameLinW'(MAX_LINES);
    end else begin
      frame_count = frame_lines;
    end
  end

  // A pixel is complete at the first low sample of its second PCLK phase.
  assign line_end  = (pixels_left == LinePixW'(1));
  assign res_valid = accept && (phase == LOW2) && !in_item.pclk;

  always_comb begin
    res_item.pixel_value = gray_mode ? {8'h00, upper_byte} : {upper_byte, in_item.pin_byte};
    res_item.pixel_index = write_index;
    res_item.frame_last  = line_end && (lines_left == FrameLinW'(1));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_pixels <= LinePixelsReset;
      frame_lines <= FrameLinesReset;
      gray_mode   <= 1'b0;
    end else if (cfg.write) begin
      unique case (cfg.index)
        CfgLinePixels: line_pixels <= cfg.data;
        CfgFrameLines: frame_lines <= cfg.data[FrameLinW-1:0];
        CfgGrayMode:   gray_mode   <= cfg.data[0];
        default:       ;
      endcase
    end
  end

  // Capture sequencer: one step per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= IDLE;
      pixels_left <= '0;
      lines_left  <= '0;
      write_index <= '0;
      upper_byte  <= '0;
    end else if (accept) begin
      unique case (phase)
        IDLE: begin
          if (in_item.start_req) phase <= VS_HIGH;
        end
        VS_HIGH: begin
          if (in_item.vsync) phase <= VS_LOW;
        end
        VS_LOW: begin
          if (!in_item.vsync) begin
            write_index <= '0;
            lines_left  <= frame_count;
            phase       <= (frame_count == '0) ? IDLE : HREF_WAIT;
          end
        end
        HREF_WAIT: begin
          if (in_item.href) begin
            pixels_left <= line_count;
            if (line_count != '0) begin
              phase <= LOW1;
            end else begin
              lines_left <= lines_left - FrameLinW'(1);
              phase      <= (lines_left == FrameLinW'(1)) ? IDLE : HREF_WAIT;
            end
          end
        end
        LOW1: begin
          if (!in_item.pclk) begin
            upper_byte <= in_item.pin_byte;
            phase      <= HIGH1;
          end
        end
        HIGH1: begin
          if (in_item.pclk) phase <= LOW2;
        end
        LOW2: begin
          if (!in_item.pclk) begin
            write_index <= write_index + IndexW'(1);
            pixels_left <= pixels_left - LinePixW'(1);
            if (line_end) lines_left <= lines_left - FrameLinW'(1);
            phase <= HIGH2;
          end
        end
        HIGH2: begin
          if (in_item.pclk) begin
            if (pixels_left != '0) begin
              phase <= LOW1;
            end else if (lines_left != '0) begin
              phase <= HREF_WAIT;
            end else begin
              phase <= IDLE;
            end
          end
        end
        default: phase <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/dvpc_queue.sv -----
// Back end: two-entry pixel queue that presents results on the output channel.
`default_nettype none
module dvpc_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire dvpc_pkg::out_item_t push_item,
  output logic                     has_room,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dvpc_pkg::out_item_t      out_data
);
  import dvpc_pkg::*;

  out_item_t  mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Storage for queued pixels.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire
